// ===== rtl/core/imf_pkg.sv =====
package imf_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned CAP_WIDTH_DEF    = 16;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned VTX_W      = 6;
  localparam int unsigned CAP_IN_W   = 16;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned VCNT_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;
  localparam logic [VTX_W-1:0]  SRC_RESET  = 6'd0;
  localparam logic [VTX_W-1:0]  SNK_RESET  = 6'd63;

  typedef enum logic [OP_W-1:0] {
    OP_SET_CAP  = 2'd0,
    OP_SOLVE    = 2'd1,
    OP_INCREASE = 2'd2,
    OP_DECREASE = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 2'd0,
    CFG_SOURCE       = 2'd1,
    CFG_SINK         = 2'd2
  } cfg_idx_e;

  typedef enum logic [5:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_ACCEPT,
    CMD_SET_WR,
    CMD_EDGE_RD,
    CMD_EDGE_LAT,
    CMD_INC_WR,
    CMD_DEC_WR,
    CMD_TOTAL_ADD,
    CMD_TOTAL_DEC,
    CMD_ARGS_MAIN,
    CMD_ARGS_EDGE,
    CMD_ARGS_SNK,
    CMD_ARGS_SRC,
    CMD_AUG_CLR,
    CMD_AUG_INIT,
    CMD_POP_RD,
    CMD_POP_LVL,
    CMD_POP_LAT,
    CMD_SCAN_RD,
    CMD_SCAN_EV,
    CMD_PATH_INIT,
    CMD_PAR_RD,
    CMD_PATH_RD,
    CMD_PATH_EV,
    CMD_PUSH_INIT,
    CMD_PUSH_RD,
    CMD_MV_SETUP,
    CMD_MV_RD,
    CMD_MV_WR1,
    CMD_MV_WR2,
    CMD_GOT_ZERO,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    op_e  op;
    logic set_ok;
    logic edge_ok;
    logic cap_zero;
    logic cap_at_max;
    logic saturated;
    logic aug_ok;
    logic idx_last;
    logic q_nonempty;
    logic scan_hit;
    logic scan_is_t;
    logic p_is_s;
    logic got_nz;
    logic clr_last;
  } status_t;

endpackage

// ===== rtl/core/imf_ram.sv =====
module imf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/imf_datapath.sv =====
module imf_datapath import imf_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned CAP_WIDTH    = CAP_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_e                  cmd_i,
  output status_t               st_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [VTX_W-1:0]      from_vertex_i,
  input  logic [VTX_W-1:0]      to_vertex_i,
  input  logic [CAP_IN_W-1:0]   capacity_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [TOTAL_W-1:0]    max_flow_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = (VW + 1 > VCNT_W) ? VW + 1 : VCNT_W;
  localparam int unsigned LW = VW + 1;
  localparam int unsigned AW = 2 * VW;
  localparam int unsigned MDEPTH = 1 << AW;
  localparam int unsigned FW = CAP_WIDTH + 1;
  localparam int unsigned RW = CAP_WIDTH + 2;
  localparam int unsigned SW = ((FW > TOTAL_W) ? FW : TOTAL_W) + 1;
  localparam logic [CAP_WIDTH-1:0] CAP_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic signed [RW-1:0] RES_HUGE = {1'b0, {(RW - 1){1'b1}}};

  // registers
  op_e                   op_q;
  logic [VTX_W-1:0]      a_q, b_q;
  logic [CAP_WIDTH-1:0]  cin_q;
  logic [VCNT_W-1:0]     vcnt_q;
  logic [VTX_W-1:0]      src_q, snk_q;
  logic [VW-1:0]         s_q, t_q, idx_q, u_q, cur_q, p_q;
  logic                  lim_q, aug_ok_q;
  logic [LW-1:0]         head_q, tail_q, lvlu_q;
  logic signed [RW-1:0]  m_q;
  logic [FW-1:0]         newf_q, got_q, eflow_q;
  logic [CAP_WIDTH-1:0]  ecap_q;
  logic [TOTAL_W-1:0]    total_q, max_flow_q;
  logic [AW-1:0]         clr_q;

  // memory ports
  logic                  cap_we, flow_we, lvl_we, par_we, q_we;
  logic [AW-1:0]         cap_wa, cap_ra, flow_wa, flow_ra;
  logic [CAP_WIDTH-1:0]  cap_wd, cap_rd;
  logic [FW-1:0]         flow_wd, flow_rd;
  logic [VW-1:0]         lvl_wa, lvl_ra, par_wa, par_ra, q_wa, q_ra;
  logic [LW-1:0]         lvl_wd, lvl_rd;
  logic [VW-1:0]         par_wd, par_rd, q_wd, q_rd;

  logic [CW-1:0]         n_c, vc_ext, a_ext, b_ext, src_ext, snk_ext, s_sel, t_sel;
  logic [VW-1:0]         a_ix, b_ix;
  logic signed [RW-1:0]  r_mem, r_edge;
  logic                  scan_hit, scan_is_t, tail_room;
  logic [FW-1:0]         m_fw;
  logic [SW-1:0]         sum_c;

  assign vc_ext  = CW'(vcnt_q);
  assign a_ext   = CW'(a_q);
  assign b_ext   = CW'(b_q);
  assign src_ext = CW'(src_q);
  assign snk_ext = CW'(snk_q);
  assign a_ix    = a_ext[VW-1:0];
  assign b_ix    = b_ext[VW-1:0];

  always_comb begin
    if (vc_ext < CW'(2)) begin
      n_c = CW'(2);
    end else if (vc_ext > CW'(MAX_VERTICES)) begin
      n_c = CW'(MAX_VERTICES);
    end else begin
      n_c = vc_ext;
    end
  end

  always_comb begin
    s_sel = src_ext;
    t_sel = snk_ext;
    case (cmd_i)
      CMD_ARGS_EDGE: begin
        s_sel = a_ext;
        t_sel = b_ext;
      end
      CMD_ARGS_SNK: begin
        s_sel = snk_ext;
        t_sel = b_ext;
      end
      CMD_ARGS_SRC: begin
        s_sel = a_ext;
        t_sel = src_ext;
      end
      default: begin
      end
    endcase
  end

  assign r_mem  = $signed({2'b00, cap_rd}) - $signed({flow_rd[FW-1], flow_rd});
  assign r_edge = $signed({2'b00, ecap_q}) - $signed({eflow_q[FW-1], eflow_q});
  assign scan_hit  = (lvl_rd == '0) && !r_mem[RW-1] && (r_mem != '0);
  assign scan_is_t = (idx_q == t_q);
  assign tail_room = (tail_q < LW'(MAX_VERTICES));
  assign m_fw      = FW'(m_q);
  assign sum_c     = SW'(total_q) + SW'(got_q);

  always_comb begin
    st_o.op         = op_q;
    st_o.set_ok     = (a_ext < CW'(MAX_VERTICES)) && (b_ext < CW'(MAX_VERTICES));
    st_o.edge_ok    = (a_ext < n_c) && (b_ext < n_c);
    st_o.cap_zero   = (ecap_q == '0);
    st_o.cap_at_max = (ecap_q == CAP_MAX);
    st_o.saturated  = r_edge[RW-1] || (r_edge == '0);
    st_o.aug_ok     = aug_ok_q;
    st_o.idx_last   = (CW'(idx_q) == n_c - CW'(1));
    st_o.q_nonempty = (head_q < tail_q);
    st_o.scan_hit   = scan_hit;
    st_o.scan_is_t  = scan_is_t;
    st_o.p_is_s     = (p_q == s_q);
    st_o.got_nz     = (got_q != '0);
    st_o.clr_last   = &clr_q;
  end

  // memory address and data selection
  always_comb begin
    cap_we  = 1'b0;
    cap_wa  = {a_ix, b_ix};
    cap_wd  = '0;
    cap_ra  = {a_ix, b_ix};
    flow_we = 1'b0;
    flow_wa = {p_q, cur_q};
    flow_wd = '0;
    flow_ra = {a_ix, b_ix};
    lvl_we  = 1'b0;
    lvl_wa  = idx_q;
    lvl_wd  = '0;
    lvl_ra  = idx_q;
    par_we  = 1'b0;
    par_wa  = idx_q;
    par_wd  = u_q;
    par_ra  = cur_q;
    q_we    = 1'b0;
    q_wa    = tail_q[VW-1:0];
    q_wd    = idx_q;
    q_ra    = head_q[VW-1:0];
    case (cmd_i)
      CMD_CLEAR: begin
        cap_we  = 1'b1;
        cap_wa  = clr_q;
        flow_we = 1'b1;
        flow_wa = clr_q;
      end
      CMD_SET_WR: begin
        cap_we = 1'b1;
        cap_wd = cin_q;
      end
      CMD_INC_WR: begin
        cap_we = 1'b1;
        cap_wd = ecap_q + CAP_WIDTH'(1);
      end
      CMD_DEC_WR: begin
        cap_we = 1'b1;
        cap_wd = ecap_q - CAP_WIDTH'(1);
      end
      CMD_SCAN_RD: begin
        cap_ra  = {u_q, idx_q};
        flow_ra = {u_q, idx_q};
      end
      CMD_PATH_RD: begin
        cap_ra  = {par_rd, cur_q};
        flow_ra = {par_rd, cur_q};
      end
      CMD_PUSH_RD: begin
        flow_ra = {par_rd, cur_q};
      end
      CMD_MV_RD: begin
        flow_ra = {p_q, cur_q};
      end
      CMD_MV_WR1: begin
        flow_we = 1'b1;
        flow_wd = flow_rd + m_fw;
      end
      CMD_MV_WR2: begin
        // reverse entry always mirrors the forward one
        flow_we = 1'b1;
        flow_wa = {cur_q, p_q};
        flow_wd = ~newf_q + FW'(1);
      end
      CMD_AUG_CLR: begin
        lvl_we = 1'b1;
      end
      CMD_AUG_INIT: begin
        lvl_we = 1'b1;
        lvl_wa = s_q;
        lvl_wd = LW'(1);
        q_we   = 1'b1;
        q_wa   = '0;
        q_wd   = s_q;
      end
      CMD_POP_LVL: begin
        lvl_ra = q_rd;
      end
      CMD_SCAN_EV: begin
        if (scan_hit) begin
          par_we = 1'b1;
          lvl_we = 1'b1;
          lvl_wd = lvlu_q + LW'(1);
          q_we   = !scan_is_t && tail_room;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q  <= VCNT_RESET;
      src_q   <= SRC_RESET;
      snk_q   <= SNK_RESET;
      total_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_VERTEX_COUNT) begin
          vcnt_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_SOURCE) begin
          src_q <= cfg_data_i[VTX_W-1:0];
        end else if (cfg_index_i == CFG_SINK) begin
          snk_q <= cfg_data_i[VTX_W-1:0];
        end
      end
      case (cmd_i)
        CMD_CLEAR: clr_q <= clr_q + AW'(1);
        CMD_TOTAL_ADD: begin
          if (sum_c > SW'(TOTAL_MAX)) begin
            total_q <= TOTAL_MAX;
          end else begin
            total_q <= sum_c[TOTAL_W-1:0];
          end
        end
        CMD_TOTAL_DEC: begin
          if (total_q != '0) begin
            total_q <= total_q - TOTAL_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_ACCEPT: begin
        op_q  <= op_e'(op_i);
        a_q   <= from_vertex_i;
        b_q   <= to_vertex_i;
        cin_q <= CAP_WIDTH'(capacity_i);
      end
      CMD_EDGE_LAT: begin
        ecap_q  <= cap_rd;
        eflow_q <= flow_rd;
      end
      CMD_ARGS_MAIN, CMD_ARGS_EDGE, CMD_ARGS_SNK, CMD_ARGS_SRC: begin
        s_q      <= s_sel[VW-1:0];
        t_q      <= t_sel[VW-1:0];
        lim_q    <= (cmd_i != CMD_ARGS_MAIN);
        aug_ok_q <= (s_sel < n_c) && (t_sel < n_c) && (s_sel != t_sel);
        idx_q    <= '0;
      end
      CMD_AUG_CLR: idx_q <= idx_q + VW'(1);
      CMD_AUG_INIT: begin
        head_q <= '0;
        tail_q <= LW'(1);
      end
      CMD_POP_RD: head_q <= head_q + LW'(1);
      CMD_POP_LVL: u_q <= q_rd;
      CMD_POP_LAT: begin
        lvlu_q <= lvl_rd;
        idx_q  <= '0;
      end
      CMD_SCAN_EV: begin
        if (scan_hit && !scan_is_t && tail_room) begin
          tail_q <= tail_q + LW'(1);
        end
        idx_q <= idx_q + VW'(1);
      end
      CMD_PATH_INIT: begin
        cur_q <= t_q;
        m_q   <= RES_HUGE;
      end
      CMD_PATH_RD: p_q <= par_rd;
      CMD_PATH_EV: begin
        if (r_mem < m_q) begin
          m_q <= r_mem;
        end
        cur_q <= p_q;
      end
      CMD_PUSH_INIT: begin
        cur_q <= t_q;
        if (lim_q && (m_q > RW'(1))) begin
          m_q   <= RW'(1);
          got_q <= FW'(1);
        end else begin
          got_q <= m_fw;
        end
      end
      CMD_PUSH_RD: p_q <= par_rd;
      CMD_MV_SETUP: begin
        p_q   <= b_ix;
        cur_q <= a_ix;
        m_q   <= RW'(1);
      end
      CMD_MV_WR1: newf_q <= flow_rd + m_fw;
      CMD_MV_WR2: cur_q <= p_q;
      CMD_GOT_ZERO: got_q <= '0;
      // result register only loads when the result is handed out
      CMD_RESULT: max_flow_q <= total_q;
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign max_flow_o = max_flow_q;

  imf_ram #(.WIDTH(CAP_WIDTH), .DEPTH(MDEPTH)) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (cap_wa),
    .wdata_i (cap_wd),
    .raddr_i (cap_ra),
    .rdata_o (cap_rd)
  );

  imf_ram #(.WIDTH(FW), .DEPTH(MDEPTH)) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (flow_we),
    .waddr_i (flow_wa),
    .wdata_i (flow_wd),
    .raddr_i (flow_ra),
    .rdata_o (flow_rd)
  );

  imf_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_wa),
    .wdata_i (lvl_wd),
    .raddr_i (lvl_ra),
    .rdata_o (lvl_rd)
  );

  imf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_wa),
    .wdata_i (par_wd),
    .raddr_i (par_ra),
    .rdata_o (par_rd)
  );

  imf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_wa),
    .wdata_i (q_wd),
    .raddr_i (q_ra),
    .rdata_o (q_rd)
  );

endmodule

// ===== rtl/core/imf_ctrl.sv =====
module imf_ctrl import imf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t st_i,
  output cmd_e    cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_EDGE_RD,
    S_EDGE_LAT,
    S_EDGE_EV,
    S_ARGS,
    S_AUG_CHK,
    S_AUG_CLR,
    S_AUG_INIT,
    S_POP,
    S_POP_LVL,
    S_POP_LAT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_PATH_INIT,
    S_PATH_PAR,
    S_PATH_RD,
    S_PATH_EV,
    S_PUSH_INIT,
    S_PUSH_PAR,
    S_PUSH_RD,
    S_PUSH_WR1,
    S_PUSH_WR2,
    S_AUG_FAIL,
    S_AUG_RET,
    S_TOTAL_DEC,
    S_DMV_SETUP,
    S_DMV_RD,
    S_DMV_WR1,
    S_DMV_WR2,
    S_DEC_WR,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    CTX_SOLVE,
    CTX_INC,
    CTX_DEC_EDGE,
    CTX_DEC_SNK,
    CTX_DEC_SRC
  } ctx_e;

  state_e state_q;
  ctx_e   ctx_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      S_CLEAR:    cmd_o = CMD_CLEAR;
      S_IDLE:     cmd_o = in_valid_i ? CMD_ACCEPT : CMD_NONE;
      S_DISPATCH: begin
        if (st_i.op == OP_SET_CAP && st_i.set_ok) begin
          cmd_o = CMD_SET_WR;
        end
      end
      S_EDGE_RD:  cmd_o = CMD_EDGE_RD;
      S_EDGE_LAT: cmd_o = CMD_EDGE_LAT;
      S_EDGE_EV: begin
        if (st_i.op == OP_INCREASE && !st_i.cap_at_max) begin
          cmd_o = CMD_INC_WR;
        end
      end
      S_ARGS: begin
        case (ctx_q)
          CTX_DEC_EDGE: cmd_o = CMD_ARGS_EDGE;
          CTX_DEC_SNK:  cmd_o = CMD_ARGS_SNK;
          CTX_DEC_SRC:  cmd_o = CMD_ARGS_SRC;
          default:      cmd_o = CMD_ARGS_MAIN;
        endcase
      end
      S_AUG_CLR:   cmd_o = CMD_AUG_CLR;
      S_AUG_INIT:  cmd_o = CMD_AUG_INIT;
      S_POP:       cmd_o = st_i.q_nonempty ? CMD_POP_RD : CMD_NONE;
      S_POP_LVL:   cmd_o = CMD_POP_LVL;
      S_POP_LAT:   cmd_o = CMD_POP_LAT;
      S_SCAN_RD:   cmd_o = CMD_SCAN_RD;
      S_SCAN_EV:   cmd_o = CMD_SCAN_EV;
      S_PATH_INIT: cmd_o = CMD_PATH_INIT;
      S_PATH_PAR:  cmd_o = CMD_PAR_RD;
      S_PATH_RD:   cmd_o = CMD_PATH_RD;
      S_PATH_EV:   cmd_o = CMD_PATH_EV;
      S_PUSH_INIT: cmd_o = CMD_PUSH_INIT;
      S_PUSH_PAR:  cmd_o = CMD_PAR_RD;
      S_PUSH_RD:   cmd_o = CMD_PUSH_RD;
      S_PUSH_WR1:  cmd_o = CMD_MV_WR1;
      S_PUSH_WR2:  cmd_o = CMD_MV_WR2;
      S_AUG_FAIL:  cmd_o = CMD_GOT_ZERO;
      S_AUG_RET: begin
        if (ctx_q == CTX_INC || (ctx_q == CTX_SOLVE && st_i.got_nz)) begin
          cmd_o = CMD_TOTAL_ADD;
        end
      end
      S_TOTAL_DEC: cmd_o = CMD_TOTAL_DEC;
      S_DMV_SETUP: cmd_o = CMD_MV_SETUP;
      S_DMV_RD:    cmd_o = CMD_MV_RD;
      S_DMV_WR1:   cmd_o = CMD_MV_WR1;
      S_DMV_WR2:   cmd_o = CMD_MV_WR2;
      S_DEC_WR:    cmd_o = CMD_DEC_WR;
      S_RESP:      cmd_o = (!out_valid_q || out_ready_i) ? CMD_RESULT : CMD_NONE;
      default:     cmd_o = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ctx_q       <= CTX_SOLVE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (st_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (st_i.op)
            OP_SET_CAP: state_q <= S_RESP;
            OP_SOLVE: begin
              ctx_q   <= CTX_SOLVE;
              state_q <= S_ARGS;
            end
            default: state_q <= st_i.edge_ok ? S_EDGE_RD : S_RESP;
          endcase
        end
        S_EDGE_RD:  state_q <= S_EDGE_LAT;
        S_EDGE_LAT: state_q <= S_EDGE_EV;
        S_EDGE_EV: begin
          if (st_i.op == OP_INCREASE) begin
            ctx_q   <= CTX_INC;
            state_q <= S_ARGS;
          end else if (st_i.cap_zero) begin
            state_q <= S_RESP;
          end else if (st_i.saturated) begin
            ctx_q   <= CTX_DEC_EDGE;
            state_q <= S_ARGS;
          end else begin
            state_q <= S_DEC_WR;
          end
        end
        S_ARGS:     state_q <= S_AUG_CHK;
        S_AUG_CHK:  state_q <= st_i.aug_ok ? S_AUG_CLR : S_AUG_FAIL;
        S_AUG_CLR: begin
          if (st_i.idx_last) begin
            state_q <= S_AUG_INIT;
          end
        end
        S_AUG_INIT: state_q <= S_POP;
        S_POP:      state_q <= st_i.q_nonempty ? S_POP_LVL : S_AUG_FAIL;
        S_POP_LVL:  state_q <= S_POP_LAT;
        S_POP_LAT:  state_q <= S_SCAN_RD;
        S_SCAN_RD:  state_q <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (st_i.scan_hit && st_i.scan_is_t) begin
            state_q <= S_PATH_INIT;
          end else if (st_i.idx_last) begin
            state_q <= S_POP;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_PATH_INIT: state_q <= S_PATH_PAR;
        S_PATH_PAR:  state_q <= S_PATH_RD;
        S_PATH_RD:   state_q <= S_PATH_EV;
        S_PATH_EV:   state_q <= st_i.p_is_s ? S_PUSH_INIT : S_PATH_PAR;
        S_PUSH_INIT: state_q <= S_PUSH_PAR;
        S_PUSH_PAR:  state_q <= S_PUSH_RD;
        S_PUSH_RD:   state_q <= S_PUSH_WR1;
        S_PUSH_WR1:  state_q <= S_PUSH_WR2;
        S_PUSH_WR2:  state_q <= st_i.p_is_s ? S_AUG_RET : S_PUSH_PAR;
        S_AUG_FAIL:  state_q <= S_AUG_RET;
        S_AUG_RET: begin
          case (ctx_q)
            CTX_SOLVE:    state_q <= st_i.got_nz ? S_ARGS : S_RESP;
            CTX_INC:      state_q <= S_RESP;
            CTX_DEC_EDGE: state_q <= st_i.got_nz ? S_DMV_SETUP : S_TOTAL_DEC;
            CTX_DEC_SNK: begin
              ctx_q   <= CTX_DEC_SRC;
              state_q <= S_ARGS;
            end
            default: state_q <= S_DMV_SETUP;
          endcase
        end
        S_TOTAL_DEC: begin
          ctx_q   <= CTX_DEC_SNK;
          state_q <= S_ARGS;
        end
        S_DMV_SETUP: state_q <= S_DMV_RD;
        S_DMV_RD:    state_q <= S_DMV_WR1;
        S_DMV_WR1:   state_q <= S_DMV_WR2;
        S_DMV_WR2:   state_q <= S_DEC_WR;
        S_DEC_WR:    state_q <= S_RESP;
        S_RESP: begin
          // result register loads from the total on the way back to idle
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/incremental_max_flow_unit.sv =====
// operations: set_capacity needs no search; increase adds one search; decrease, on a saturated
// edge, adds one search, or three searches if the first finds no path; solve runs its searches
// search: set-up, a scan per dequeued vertex, work per path edge and a finish; it stops
// at once when source or sink is unusable; solve repeats it until no path is left
// throughput: one item at a time, the next is taken once the result register is free
// reset: async active low, then a clearing pass over 4**clog2(MAX_VERTICES) entries (4096)
module incremental_max_flow_unit import imf_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned CAP_WIDTH    = CAP_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [VTX_W-1:0]      from_vertex_i,
  input  logic [VTX_W-1:0]      to_vertex_i,
  input  logic [CAP_IN_W-1:0]   capacity_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TOTAL_W-1:0]    max_flow_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_e    cmd;
  status_t st;

  imf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  imf_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .CAP_WIDTH    (CAP_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .op_i          (op_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .capacity_i    (capacity_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .max_flow_o    (max_flow_o)
  );

endmodule

// ===== rtl/core/imf_checker.sv =====
module imf_checker import imf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [TOTAL_W-1:0] max_flow_o
);

  // one item in flight: no new item right after one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(max_flow_o))
    else $error("stalled result changed");

  // a fresh result comes with the block back at idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result presented while still busy");

  // clearing pass keeps input closed right after reset
  a_reset_busy: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_o)
    else $error("input open during memory clear");

endmodule

bind incremental_max_flow_unit imf_checker u_imf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .max_flow_o  (max_flow_o)
);
